>>> rtl/core/wrrs_pkg.sv
// ----------------------------------------------------------------------------
// Weighted random retry selector package
// Shared constants, action and register codes, and the control and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wrrs_pkg;

  localparam int MAX_CANDIDATES = 32;
  localparam int WEIGHT_BITS    = 8;
  localparam int RANDOM_BITS    = 16;

  localparam int LANE_BITS     = 8;
  localparam int LANES_PER_REG = 8;
  localparam int WREG_COUNT    = 4;
  localparam int CFG_W         = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int COUNT_W       = 6;
  localparam int CAND_W        = 5;
  localparam int ACTION_W      = 2;
  localparam int RAND_IN_W     = 16;

  localparam int IDX_W  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int WGT_W  = (WEIGHT_BITS < LANE_BITS) ? WEIGHT_BITS : LANE_BITS;
  localparam int TOT_W  = WGT_W + $clog2(MAX_CANDIDATES + 1);
  localparam int RND_W  = (RANDOM_BITS < RAND_IN_W) ? RANDOM_BITS : RAND_IN_W;
  localparam int PROD_W = RANDOM_BITS + TOT_W;

  localparam logic [CFG_W-1:0] WEIGHT_RESET = 64'h0101_0101_0101_0101;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(32);

  localparam logic [ACTION_W-1:0] ACT_RUN  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DONE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_W0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_W1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_W2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_W3    = 3'd4;

  typedef struct packed {
    logic                load_req;
    logic                update;
    logic                sum_step;
    logic                mul;
    logic                scan_step;
    logic                res_load;
    logic [ACTION_W-1:0] res_action;
    logic                out_load;
  } wrrs_cmd_t;

  typedef struct packed {
    logic kind;
    logic failed;
    logic idx_last;
    logic total_zero;
    logic eligible;
    logic above;
    logic out_free;
  } wrrs_status_t;

endpackage

`default_nettype wire

>>> rtl/core/wrrs_dp.sv
// ----------------------------------------------------------------------------
// Weighted random retry selector datapath
// Configuration registers, tried mask, weight accumulator, scaling
// multiplier, scan compare and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module wrrs_dp import wrrs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 kind,
  input  wire logic [CAND_W-1:0]    prev_candidate,
  input  wire logic                 prev_failed,
  input  wire logic [RAND_IN_W-1:0] random_fraction,
  input  wire wrrs_cmd_t            cmd,
  output wrrs_status_t              st,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic [ACTION_W-1:0]       action,
  output logic [CAND_W-1:0]         chosen_candidate
);

  logic [COUNT_W-1:0]        cand_count;
  logic [CFG_W-1:0]          wreg [WREG_COUNT];
  logic                      kind_r;
  logic                      failed_r;
  logic [CAND_W-1:0]         prev_r;
  logic [RND_W-1:0]          rnd;
  logic [MAX_CANDIDATES-1:0] tried;
  logic [MAX_CANDIDATES-1:0] prev_sel;
  logic [IDX_W-1:0]          idx;
  logic [TOT_W-1:0]          total;
  logic [TOT_W-1:0]          scaled;
  logic [TOT_W-1:0]          run;
  logic [TOT_W-1:0]          run_next;
  logic [ACTION_W-1:0]       res_action;
  logic [CAND_W-1:0]         res_cand;
  logic [WGT_W-1:0]          wlane [MAX_CANDIDATES];
  logic [WGT_W-1:0]          w_cur;
  logic [TOT_W-1:0]          w_add;
  logic [COUNT_W-1:0]        count_eff;
  logic [RANDOM_BITS-1:0]    rnd_ext;
  logic [PROD_W-1:0]         product;
  logic                      eligible;

  for (genvar i = 0; i < MAX_CANDIDATES; i++) begin : g_lane
    assign wlane[i]    = wreg[i / LANES_PER_REG][(i % LANES_PER_REG) * LANE_BITS +: WGT_W];
    assign prev_sel[i] = (prev_r == CAND_W'(i));
  end

  assign count_eff = (cand_count > COUNT_W'(MAX_CANDIDATES)) ? COUNT_W'(MAX_CANDIDATES)
                                                             : cand_count;
  assign w_cur     = wlane[idx];
  assign eligible  = (COUNT_W'(idx) < count_eff) && !tried[idx];
  assign w_add     = eligible ? TOT_W'(w_cur) : '0;
  assign run_next  = run + w_add;
  assign rnd_ext   = RANDOM_BITS'(rnd);
  assign product   = PROD_W'(rnd_ext) * PROD_W'(total);

  assign st.kind       = kind_r;
  assign st.failed     = failed_r;
  assign st.idx_last   = (idx == IDX_W'(MAX_CANDIDATES - 1));
  assign st.total_zero = (total == '0);
  assign st.eligible   = eligible;
  assign st.above      = (run_next > scaled);
  assign st.out_free   = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_count <= COUNT_RESET;
      for (int k = 0; k < WREG_COUNT; k++) begin
        wreg[k] <= WEIGHT_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNT: cand_count <= cfg_data[COUNT_W-1:0];
        CFG_W0:    wreg[0] <= cfg_data;
        CFG_W1:    wreg[1] <= cfg_data;
        CFG_W2:    wreg[2] <= cfg_data;
        CFG_W3:    wreg[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tried <= '0;
    end else if (cmd.update) begin
      if (!kind_r) begin
        tried <= '0;
      end else if (failed_r) begin
        tried <= tried | prev_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind_r   <= kind;
      failed_r <= prev_failed;
      prev_r   <= prev_candidate;
      rnd      <= random_fraction[RND_W-1:0];
    end
    if (cmd.update || cmd.mul) begin
      idx <= '0;
    end else if (cmd.sum_step || cmd.scan_step) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.update) begin
      total <= '0;
    end else if (cmd.sum_step) begin
      total <= total + w_add;
    end
    if (cmd.mul) begin
      scaled <= product[PROD_W-1 -: TOT_W];
      run    <= '0;
    end else if (cmd.scan_step) begin
      run <= run_next;
    end
    if (cmd.res_load) begin
      res_action <= cmd.res_action;
      res_cand   <= (cmd.res_action == ACT_RUN) ? CAND_W'(idx) : '0;
    end
    if (cmd.out_load) begin
      action           <= res_action;
      chosen_candidate <= res_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  a_run_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> run <= total)
    else $error("Running sum passed the total during the scan.");

  a_scaled_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |=> (total == '0) || (scaled < total))
    else $error("Scaled random value is not below the total weight.");

endmodule

`default_nettype wire

>>> rtl/core/wrrs_ctrl.sv
// ----------------------------------------------------------------------------
// Weighted random retry selector controller
// Sequences one request through mask update, weight sum, scaling, scan and result
// delivery; a success report goes from update to delivery, a zero total skips the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module wrrs_ctrl import wrrs_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  input  wire wrrs_status_t st,
  output wrrs_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (st.kind && !st.failed) begin
          cmd.res_load   = 1'b1;
          cmd.res_action = ACT_DONE;
          state_next     = S_OUT;
        end else begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (st.idx_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (st.total_zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_action = ACT_NONE;
          state_next     = S_OUT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.eligible && st.above) begin
          cmd.res_load   = 1'b1;
          cmd.res_action = ACT_RUN;
          state_next     = S_OUT;
        end else if (st.idx_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_action = ACT_NONE;
          state_next     = S_OUT;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_scan_hits: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && st.idx_last |-> st.above)
    else $error("Scan reached the last candidate without covering the scaled value.");

endmodule

`default_nettype wire

>>> rtl/core/weighted_random_retry_selector.sv
// ----------------------------------------------------------------------------
// Weighted random retry selector
// Weighted lottery over up to 32 candidates, drawn without replacement.
//
//   Channel   Handshake            Payload
//   request   req_valid/req_stall  kind, prev_candidate, prev_failed,
//                                  random_fraction
//   result    rsp_valid/rsp_stall  action, chosen_candidate
//   config    cfg_we               cfg_index, cfg_data
//
// A success report goes from acceptance through the update state to the output
// state; a draw adds one pass of the single weight accumulator over all 32
// candidates, the scaling step and a second scan pass that stops at the pick.
// Requests are taken one at a time; the next is accepted as soon as the
// result is in the output register, even while that result is stalled.
// Reset is synchronous and sets every weight to 1, the count to 32 and
// clears the tried mask; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_random_retry_selector import wrrs_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic                 kind,
  input  wire logic [CAND_W-1:0]    prev_candidate,
  input  wire logic                 prev_failed,
  input  wire logic [RAND_IN_W-1:0] random_fraction,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic [ACTION_W-1:0]       action,
  output logic [CAND_W-1:0]         chosen_candidate,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  wrrs_cmd_t    cmd;
  wrrs_status_t st;

  wrrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  wrrs_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .kind             (kind),
    .prev_candidate   (prev_candidate),
    .prev_failed      (prev_failed),
    .random_fraction  (random_fraction),
    .cmd              (cmd),
    .st               (st),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .action           (action),
    .chosen_candidate (chosen_candidate)
  );

endmodule

`default_nettype wire
